FILE: rtl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache_macros
// Assertion macros used by the cache datapath RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] DATA_MISS = 32'hFFFF_FFFF;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic age;
    logic commit;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_age;
    logic out_busy;
  } ctl_sts_t;

endpackage

FILE: rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: scan pass, decision, age pass, commit and result push.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lkv_pkg::ctl_sts_t  sts_i,
  output lkv_pkg::ctl_cmd_t  cmd_o
);
  import lkv_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_SDRAIN = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_AGE    = 8'b0001_0000,
    ST_ADRAIN = 8'b0010_0000,
    ST_COMMIT = 8'b0100_0000,
    ST_PUSH   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sts_i.idx_last) state_nxt = ST_SDRAIN;
      ST_SDRAIN: state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = sts_i.need_age ? ST_AGE : ST_COMMIT;
      ST_AGE:    if (sts_i.idx_last) state_nxt = ST_ADRAIN;
      ST_ADRAIN: state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_PUSH;
      ST_PUSH:   if (!sts_i.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready     = (state_r == ST_IDLE);
  assign cmd_o.load    = (state_r == ST_IDLE) && in_tvalid;
  assign cmd_o.scan    = (state_r == ST_SCAN);
  assign cmd_o.decide  = (state_r == ST_DECIDE);
  assign cmd_o.age     = (state_r == ST_AGE);
  assign cmd_o.commit  = (state_r == ST_COMMIT);
  assign cmd_o.push    = (state_r == ST_PUSH) && !sts_i.out_busy;

endmodule

FILE: rtl/lkv_dpath.sv
// ----------------------------------------------------------------------------
// lkv_dpath
// Entry memories, valid bits, scan and age pipelines, result register.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lkv_dpath #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkv_pkg::ctl_cmd_t           cmd_i,
  output lkv_pkg::ctl_sts_t           sts_o,
  input  logic [63:0]                 in_tdata,
  input  logic                        in_tuser,
  input  logic                        cfg_valid,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lkv_pkg::DATA_W-1:0]  out_tdata,
  output logic [1:0]                  out_tuser
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [DATA_W-1:0] data_mem [ENTRIES];
  logic [AW-1:0]     age_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     used_r;
  logic [IW-1:0]     idx_r;
  logic [IW-1:0]     rd_idx_r;
  logic              scan_vld_r;
  logic              age_vld_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_age_r;

  logic              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;

  logic              found_r;
  logic              free_found_r;
  logic [IW-1:0]     pos_r;
  logic [IW-1:0]     free_r;
  logic [IW-1:0]     old_r;
  logic [DATA_W-1:0] hit_data_r;
  logic [AW-1:0]     hit_age_r;
  logic              full_r;
  logic [IW-1:0]     slot_r;
  logic [AW-1:0]     a_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_hit_r;
  logic              out_evict_r;

  logic [EW-1:0]     cap_ext;
  logic [EW-1:0]     eff_cap;
  logic              full_now;
  logic [AW-1:0]     victim_age;
  logic              need_age;
  logic              insert;
  logic              age_bump;
  logic              age_we;
  logic [IW-1:0]     age_waddr;
  logic [AW-1:0]     age_wdata;
  logic              idx_last;

  assign cap_ext    = EW'(cap_r);
  assign eff_cap    = (cap_ext == '0) ? EW'(1) :
                      ((cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext);
  assign full_now   = (EW'(used_r) >= eff_cap);
  assign victim_age = AW'(used_r - CW'(1));
  assign need_age   = found_r || (cmd_r == CMD_SET);
  assign insert     = (cmd_r == CMD_SET) && !found_r && !full_r;
  assign idx_last   = (idx_r == IW'(ENTRIES - 1));

  assign age_bump  = age_vld_r && valid_r[rd_idx_r] && (rd_idx_r != slot_r) && (rd_age_r < a_r);
  assign age_we    = age_bump || (cmd_i.commit && need_age);
  assign age_waddr = cmd_i.commit ? slot_r : rd_idx_r;
  assign age_wdata = cmd_i.commit ? '0 : (rd_age_r + AW'(1));

  assign sts_o.idx_last = idx_last;
  assign sts_o.need_age = need_age;
  assign sts_o.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd_i.commit && (cmd_r == CMD_SET)) begin
      key_mem[slot_r] <= key_r;
    end
    rd_key_r <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit && (cmd_r == CMD_SET)) begin
      data_mem[slot_r] <= value_r;
    end
    rd_data_r <= data_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    rd_age_r <= age_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r   <= in_tuser;
      key_r   <= in_tdata[31:0];
      value_r <= in_tdata[63:32];
    end
    rd_idx_r <= idx_r;
    if (scan_vld_r && valid_r[rd_idx_r]) begin
      if ((rd_key_r == key_r) && !found_r) begin
        pos_r      <= rd_idx_r;
        hit_data_r <= rd_data_r;
        hit_age_r  <= rd_age_r;
      end
      if (rd_age_r == victim_age) begin
        old_r <= rd_idx_r;
      end
    end
    if (cmd_i.scan && !valid_r[idx_r] && !free_found_r) begin
      free_r <= idx_r;
    end
    if (cmd_i.decide) begin
      full_r <= full_now;
      if (found_r) begin
        slot_r <= pos_r;
        a_r    <= hit_age_r;
      end else if (full_now) begin
        slot_r <= old_r;
        a_r    <= victim_age;
      end else begin
        slot_r <= free_r;
        a_r    <= AW'(used_r);
      end
    end
    if (cmd_i.push) begin
      out_hit_r   <= found_r;
      out_evict_r <= (cmd_r == CMD_SET) && !found_r && full_r;
      if (cmd_r == CMD_SET) begin
        out_data_r <= value_r;
      end else begin
        out_data_r <= found_r ? hit_data_r : DATA_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      used_r       <= '0;
      valid_r      <= '0;
      idx_r        <= '0;
      scan_vld_r   <= 1'b0;
      age_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      scan_vld_r <= cmd_i.scan;
      age_vld_r  <= cmd_i.age;
      if (cmd_i.load || cmd_i.decide) begin
        idx_r <= '0;
      end else if ((cmd_i.scan || cmd_i.age) && !idx_last) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmd_i.load) begin
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (scan_vld_r && valid_r[rd_idx_r] && (rd_key_r == key_r)) begin
          found_r <= 1'b1;
        end
        if (cmd_i.scan && !valid_r[idx_r]) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd_i.commit && insert) begin
        valid_r[slot_r] <= 1'b1;
        used_r          <= used_r + CW'(1);
      end
      if (cmd_i.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_evict_r, out_hit_r};

  `LKV_ASSERT_NOW(a_used_bound, 1'b1, used_r <= CW'(ENTRIES), "entry count above depth")
  `LKV_ASSERT_NEXT(a_insert_count, cmd_i.commit && insert, used_r == $past(used_r) + CW'(1), "insert did not grow count")
  `LKV_ASSERT_NEXT(a_evict_count, cmd_i.commit && !insert, $stable(used_r), "count changed without insert")
  `LKV_ASSERT_NOW(a_hit_evict, out_valid_r, !(out_hit_r && out_evict_r), "eviction on a hit")

endmodule

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Each operation runs as sequential passes over the entry memories, one entry
// per cycle through a single registered read port: a key scan over all
// entries, then, for a hit or any set, an age update pass over all entries.
// The result is pushed after the commit, and the next beat is taken once the
// controller has returned to idle, so a new operation is not accepted before
// the last one is through. One operation is in flight at a time; the result
// register lets the next beat enter while a result waits. Valid bits reset at
// once, so there is no clearing pass. Write capacity only while the block is
// idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // key[31:0], value[63:32]
  input  logic                        in_tuser,   // cmd[0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lkv_pkg::DATA_W-1:0]  out_tdata,  // data[31:0]
  output logic [1:0]                  out_tuser,  // hit[0], evicted[1]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_data
);
  import lkv_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (ctl_sts),
    .cmd_o     (ctl_cmd)
  );

  lkv_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (ctl_cmd),
    .sts_o      (ctl_sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
